>>> sv/sde_pkg.sv
// shared types, constants and codes of the square draw engine
`timescale 1ns / 1ps
package sde_pkg;

  // canvas geometry
  localparam int MAX_SIZE  = 256;
  localparam int COORD_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W    = $clog2(MAX_SIZE + 1);
  localparam int CANVAS_AW = 2 * COORD_W;

  // field widths
  localparam int OP_W    = 2;
  localparam int FIELD_W = 8;
  localparam int PIX_W   = 8;
  localparam int CFG_SIZE_W = 9;

  // command opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // register map
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic REG_CANVAS_SIZE = 1'b0;
  localparam logic REG_BACKGROUND  = 1'b1;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_DRAW,
    JOB_READ,
    JOB_NONE
  } job_kind_e;

  // one classified command
  typedef struct packed {
    job_kind_e          kind;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [PIX_W-1:0]   color;
    logic               outline;
    logic               rejected;
  } job_t;

  // back end status seen by the top level
  typedef struct packed {
    logic busy;
    logic pix_we;
  } back_status_t;

endpackage

>>> sv/sde_cmd_if.sv
// command channel of the square draw engine
`timescale 1ns / 1ps
interface sde_cmd_if;
  import sde_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [FIELD_W-1:0] col;
  logic [FIELD_W-1:0] row;
  logic [FIELD_W-1:0] half_size;
  logic [PIX_W-1:0]   color;
  logic               outline;

  modport source (output valid, opcode, col, row, half_size, color, outline, input ready);
  modport sink   (input valid, opcode, col, row, half_size, color, outline, output ready);
endinterface

>>> sv/sde_res_if.sv
// result channel of the square draw engine
`timescale 1ns / 1ps
interface sde_res_if;
  import sde_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             rejected;

  modport source (output valid, pixel, rejected, input ready);
  modport sink   (input valid, pixel, rejected, output ready);
endinterface

>>> sv/sde_front.sv
// front end: accepts command words and classifies them into jobs
`timescale 1ns / 1ps
module sde_front (
  sde_cmd_if.sink                    cmd_i,
  input  logic [sde_pkg::CFG_SIZE_W-1:0] canvas_size_i,
  input  logic [sde_pkg::PIX_W-1:0]  background_color_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output sde_pkg::job_t              push_job_o
);
  import sde_pkg::*;

  logic [SIZE_W-1:0]  size;
  logic [SIZE_W:0]    r_ext, c_ext, d_ext, size_ext;
  logic               fits;
  logic               read_in;
  job_t               job;

  // size in use saturates at the canvas store edge
  always_comb begin
    if (canvas_size_i > CFG_SIZE_W'(MAX_SIZE)) begin
      size = SIZE_W'(MAX_SIZE);
    end else begin
      size = SIZE_W'(canvas_size_i);
    end
  end

  // bounds checks for draw and read
  assign r_ext    = (SIZE_W+1)'(cmd_i.row);
  assign c_ext    = (SIZE_W+1)'(cmd_i.col);
  assign d_ext    = (SIZE_W+1)'(cmd_i.half_size);
  assign size_ext = (SIZE_W+1)'(size);
  assign fits = (size != '0) && (r_ext >= d_ext) && (c_ext >= d_ext) &&
                (r_ext + d_ext < size_ext) && (c_ext + d_ext < size_ext) &&
                ((d_ext << 1) < size_ext);
  assign read_in = (r_ext < size_ext) && (c_ext < size_ext);

  // classify the command
  always_comb begin
    job.kind     = JOB_NONE;
    job.top      = COORD_W'(cmd_i.row - cmd_i.half_size);
    job.left     = COORD_W'(cmd_i.col - cmd_i.half_size);
    job.bottom   = COORD_W'(cmd_i.row + cmd_i.half_size);
    job.right    = COORD_W'(cmd_i.col + cmd_i.half_size);
    job.color    = cmd_i.color;
    job.outline  = cmd_i.outline;
    job.rejected = 1'b0;
    case (cmd_i.opcode)
      OP_CLEAR: begin
        job.kind    = JOB_CLEAR;
        job.top     = '0;
        job.left    = '0;
        job.bottom  = COORD_W'(MAX_SIZE - 1);
        job.right   = COORD_W'(MAX_SIZE - 1);
        job.color   = background_color_i;
        job.outline = 1'b0;
      end
      OP_DRAW: begin
        if (fits) begin
          job.kind = JOB_DRAW;
        end else begin
          job.rejected = 1'b1;
        end
      end
      OP_READ: begin
        job.top  = COORD_W'(cmd_i.row);
        job.left = COORD_W'(cmd_i.col);
        if (read_in) begin
          job.kind = JOB_READ;
        end else begin
          job.rejected = 1'b1;
        end
      end
      default: begin
        job.kind = JOB_NONE;
      end
    endcase
  end

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;
  assign push_job_o   = job;
endmodule

>>> sv/sde_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps
module sde_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_valid_i,
  output logic                      push_ready_o,
  input  sde_pkg::job_t             push_job_i,
  output logic                      pop_valid_o,
  input  logic                      pop_ready_i,
  output sde_pkg::job_t             pop_job_o,
  output logic [sde_pkg::QUEUE_LW-1:0] level_o
);
  import sde_pkg::*;

  job_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_q, rd_q;
  logic [QUEUE_LW-1:0] level_q;
  logic                push, pop;

  assign push_ready_o = (level_q != QUEUE_LW'(QUEUE_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        level_q <= level_q + 1'b1;
      end else if (pop && !push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  assign pop_job_o = slot_q[rd_q];
  assign level_o   = level_q;
endmodule

>>> sv/sde_back.sv
// back end: canvas store, pixel sweeps, pixel reads and result word
`timescale 1ns / 1ps
module sde_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  sde_pkg::job_t         pop_job_i,
  sde_res_if.source             res_o,
  output sde_pkg::back_status_t status_o
);
  import sde_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state_q, state_d;
  job_t                 job_q;
  logic [COORD_W-1:0]   row_q, col_q;
  logic [PIX_W-1:0]     canvas [MAX_SIZE * MAX_SIZE];
  logic [PIX_W-1:0]     rd_data_q;
  logic [CANVAS_AW-1:0] addr;
  logic                 pix_we;
  logic                 on_edge;
  logic                 out_valid_q;
  logic [PIX_W-1:0]     out_pixel_q;
  logic                 out_rejected_q;
  logic                 out_free;

  assign addr     = {row_q, col_q};
  assign on_edge  = (row_q == job_q.top) || (row_q == job_q.bottom) ||
                    (col_q == job_q.left) || (col_q == job_q.right);
  assign pix_we   = (state_q == ST_SWEEP) && (!job_q.outline || on_edge);
  assign out_free = !out_valid_q || res_o.ready;
  assign pop_ready_o = (state_q == ST_IDLE);

  // canvas store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      canvas[addr] <= job_q.color;
    end
    rd_data_q <= canvas[addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          case (pop_job_i.kind)
            JOB_CLEAR, JOB_DRAW: state_d = ST_SWEEP;
            JOB_READ:            state_d = ST_READ;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (col_q == job_q.right && row_q == job_q.bottom) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      default: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      job_q <= pop_job_i;
      row_q <= pop_job_i.top;
      col_q <= pop_job_i.left;
    end else if (state_q == ST_SWEEP) begin
      if (col_q == job_q.right) begin
        col_q <= job_q.left;
        if (row_q != job_q.bottom) begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_pixel_q    <= (job_q.kind == JOB_READ) ? rd_data_q : '0;
      out_rejected_q <= job_q.rejected;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.pixel    = out_pixel_q;
  assign res_o.rejected = out_rejected_q;

  assign status_o.busy   = (state_q != ST_IDLE);
  assign status_o.pix_we = pix_we;
endmodule

>>> sv/square_draw_engine.sv
// top level of the square draw engine: register port, front, queue and back end
//
//   channel  direction  handshake        word
//   cmd_i    in         valid / ready    opcode, col, row, half_size, color, outline
//   res_o    out        valid / ready    pixel, rejected
//   apb      in         psel / penable   canvas_size at 0x0, background_color at 0x4
//
// a clear sweeps MAX_SIZE*MAX_SIZE pixels, a draw (2*half_size+1)^2, any other
// word none; the back end visits one pixel per cycle, an outline writing edges only.
// reset leaves the canvas store undefined; there is no clearing pass, the
// first clear command fills it.
// a two-word queue lets the front take words while the back end sweeps, and
// a result word waits in its register while the next job runs.
`timescale 1ns / 1ps
module square_draw_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sde_cmd_if.sink                    cmd_i,
  sde_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sde_pkg::APB_AW-1:0] paddr,
  input  logic [sde_pkg::APB_DW-1:0] pwdata,
  output logic [sde_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sde_pkg::*;

  logic [CFG_SIZE_W-1:0] canvas_size_q;
  logic [PIX_W-1:0]      background_q;
  logic                  reg_sel;
  logic                  push_valid, push_ready;
  job_t                  push_job;
  logic                  pop_valid, pop_ready;
  job_t                  pop_job;
  logic [QUEUE_LW-1:0]   level;
  back_status_t          back_status;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_size_q <= CFG_SIZE_W'(256);
      background_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_CANVAS_SIZE: canvas_size_q <= pwdata[CFG_SIZE_W-1:0];
        default:         background_q  <= pwdata[PIX_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CANVAS_SIZE: prdata = APB_DW'(canvas_size_q);
      default:         prdata = APB_DW'(background_q);
    endcase
  end

  // command classification
  sde_front u_front (
    .cmd_i              (cmd_i),
    .canvas_size_i      (canvas_size_q),
    .background_color_i (background_q),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_job_o         (push_job)
  );

  // job queue
  sde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job),
    .level_o      (level)
  );

  // canvas execution
  sde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .res_o       (res_o),
    .status_o    (back_status)
  );

`ifndef SYNTHESIS
  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QUEUE_LW'(QUEUE_DEPTH))
    else $error("job queue overfilled");

  // a rejected word never carries a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.rejected |-> res_o.pixel == '0)
    else $error("rejected result with nonzero pixel");

  // pixels are written only while a job runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_status.busy |-> !back_status.pix_we)
    else $error("pixel write while back end idle");

  // a new result word follows back end activity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(back_status.busy))
    else $error("result without a job");
`endif
endmodule

>>> test/tb.sv
// self-checking testbench of the square draw engine with a canvas mirror
`timescale 1ns / 1ps
module tb;
  import sde_pkg::*;

  // no-operation opcode, only the testbench names it
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] half_size;
    logic [PIX_W-1:0]   color;
    logic               outline;
  } cmd_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             rejected;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sde_cmd_if cmd_bus ();
  sde_res_if res_bus ();

  square_draw_engine u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the canvas store and of the two registers
  logic [PIX_W-1:0]      canvas_mirror [MAX_SIZE*MAX_SIZE];
  logic [CFG_SIZE_W-1:0] size_reg;
  logic [PIX_W-1:0]      bg_reg;
  answer_t               answers_q [$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side stalls
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int size_in_use();
    return (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
  endfunction

  function automatic bit square_fits(int r, int c, int d, int sz);
    return sz > 0 && r >= d && c >= d && r + d <= sz - 1 && c + d <= sz - 1 &&
           2 * d + 1 <= sz;
  endfunction

  // apply one command to the mirror and return the word it should give
  function automatic answer_t run_canvas_cmd(cmd_word_t w);
    answer_t ans;
    int sz, r, c, d, i, j;
    ans = '0;
    sz  = size_in_use();
    r   = int'(w.row);
    c   = int'(w.col);
    d   = int'(w.half_size);
    case (w.opcode)
      OP_CLEAR: begin
        foreach (canvas_mirror[k]) canvas_mirror[k] = bg_reg;
      end
      OP_DRAW: begin
        if (!square_fits(r, c, d, sz)) begin
          ans.rejected = 1'b1;
        end else begin
          for (i = r - d; i <= r + d; i++) begin
            for (j = c - d; j <= c + d; j++) begin
              if (!w.outline || i == r - d || i == r + d || j == c - d || j == c + d)
                canvas_mirror[i * MAX_SIZE + j] = w.color;
            end
          end
        end
      end
      OP_READ: begin
        if (r < sz && c < sz) ans.pixel = canvas_mirror[r * MAX_SIZE + c];
        else ans.rejected = 1'b1;
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic cmd_word_t make_word(logic [OP_W-1:0] op, logic [FIELD_W-1:0] r,
                                          logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d,
                                          logic [PIX_W-1:0] color, logic outline);
    cmd_word_t w;
    w.opcode    = op;
    w.row       = r;
    w.col       = c;
    w.half_size = d;
    w.color     = color;
    w.outline   = outline;
    return w;
  endfunction

  task automatic log_mismatch(string what, logic [PIX_W-1:0] want_v, logic [PIX_W-1:0] got_v);
    if (mismatches < REPORT_MAX)
      $display("%s mismatch: expected %0d, got %0d (cycle %0d)", what, want_v, got_v,
               cycle_count);
    mismatches++;
  endtask

  // compare each result word with the oldest awaited one
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (answers_q.size() == 0) begin
        log_mismatch("unawaited word pixel", '0, res_bus.pixel);
      end else begin
        want = answers_q.pop_front();
        if (res_bus.pixel !== want.pixel) log_mismatch("pixel", want.pixel, res_bus.pixel);
        if (res_bus.rejected !== want.rejected)
          log_mismatch("rejected", PIX_W'(want.rejected), PIX_W'(res_bus.rejected));
      end
    end
  end

  // drive one command word, idling first at random
  task automatic send_word(cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_bus.valid     <= 1'b1;
    cmd_bus.opcode    <= w.opcode;
    cmd_bus.row       <= w.row;
    cmd_bus.col       <= w.col;
    cmd_bus.half_size <= w.half_size;
    cmd_bus.color     <= w.color;
    cmd_bus.outline   <= w.outline;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    answers_q.push_back(run_canvas_cmd(w));
  endtask

  // stop sending and wait for every awaited word
  task automatic wait_drained();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with the engine idle
  task automatic write_reg(logic idx, logic [APB_DW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_CANVAS_SIZE) size_reg = value[CFG_SIZE_W-1:0];
    else bg_reg = value[PIX_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic do_clear();
    send_word(make_word(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                        FIELD_W'($urandom), PIX_W'($urandom), 1'($urandom)));
  endtask

  task automatic do_draw(int r, int c, int d, logic [PIX_W-1:0] color, logic outline);
    send_word(make_word(OP_DRAW, FIELD_W'(r), FIELD_W'(c), FIELD_W'(d), color, outline));
  endtask

  task automatic do_read(int r, int c);
    send_word(make_word(OP_READ, FIELD_W'(r), FIELD_W'(c), FIELD_W'($urandom),
                        PIX_W'($urandom), 1'($urandom)));
  endtask

  // random word: mostly in-canvas draws and reads, some noise and no-ops
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int sz, pick, d, dmax;
    sz          = size_in_use();
    pick        = $urandom_range(99);
    w.row       = FIELD_W'($urandom);
    w.col       = FIELD_W'($urandom);
    w.half_size = FIELD_W'($urandom);
    w.color     = PIX_W'($urandom);
    w.outline   = 1'($urandom);
    if (pick < 5) begin
      w.opcode = OP_IDLE;
    end else if (pick < 15) begin
      w.opcode = pick[0] ? OP_DRAW : OP_READ;
      // keep large squares out of the noise so the run stays short
      if (w.opcode == OP_DRAW && w.half_size > 8 &&
          square_fits(int'(w.row), int'(w.col), int'(w.half_size), sz))
        w.row = w.half_size - 1'b1;
    end else if (pick < 55) begin
      w.opcode    = OP_DRAW;
      dmax        = ($urandom_range(9) == 0) ? 15 : 3;
      if (dmax > (sz - 1) / 2) dmax = (sz - 1) / 2;
      d           = $urandom_range(dmax);
      w.half_size = FIELD_W'(d);
      w.row       = FIELD_W'($urandom_range(sz - 1 - d, d));
      w.col       = FIELD_W'($urandom_range(sz - 1 - d, d));
    end else begin
      w.opcode = OP_READ;
      w.row    = FIELD_W'($urandom_range(sz - 1));
      w.col    = FIELD_W'($urandom_range(sz - 1));
    end
    return w;
  endfunction

  // clear with the registers as they come out of reset
  task automatic test_reset_defaults();
    do_clear();
    do_read(0, 0);
    do_read(255, 255);
  endtask

  // filled and border-only squares, including the largest border
  task automatic test_fill_and_outline();
    do_draw(128, 200, 2, 8'hA5, 1'b0);
    do_read(128, 200);
    do_read(130, 202);
    do_draw(10, 10, 3, 8'h5A, 1'b1);
    do_read(10, 10);
    do_read(7, 13);
    do_draw(127, 128, 127, 8'hFF, 1'b1);
    do_read(0, 1);
    do_read(128, 200);
  endtask

  // squares that leave the canvas, and the no-op word
  task automatic test_rejections();
    do_draw(255, 255, 128, 8'h80, 1'b0);
    do_draw(2, 5, 3, 8'h11, 1'b0);
    do_draw(100, 255, 1, 8'h22, 1'b1);
    send_word(make_word(OP_IDLE, FIELD_W'($urandom), FIELD_W'($urandom),
                        FIELD_W'($urandom), PIX_W'($urandom), 1'($urandom)));
  endtask

  // empty, single-pixel and oversized canvas, then a clear in white
  task automatic test_canvas_sizes();
    write_reg(REG_CANVAS_SIZE, 32'd0);
    do_draw(0, 0, 0, 8'h01, 1'b0);
    do_read(0, 0);
    write_reg(REG_CANVAS_SIZE, 32'd1);
    do_draw(0, 0, 0, 8'h07, 1'b0);
    do_read(0, 0);
    do_read(0, 1);
    write_reg(REG_CANVAS_SIZE, 32'd511);
    do_draw(254, 254, 1, 8'hC3, 1'b1);
    do_read(255, 255);
    write_reg(REG_BACKGROUND, 32'd255);
    do_clear();
    do_read(200, 3);
  endtask

  // one random phase at a given canvas size and idling mix
  task automatic test_random_traffic(int send_pct, int recv_pct, int size_val, int count);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(REG_CANVAS_SIZE, size_val);
    write_reg(REG_BACKGROUND, $urandom_range(255));
    do_clear();
    for (n = 0; n < count; n++) begin
      send_word(random_word());
      // hold off now and then until the engine has answered everything
      if (n % 12 == 11) wait_drained();
    end
  endtask

  // test sequence
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.opcode    = OP_IDLE;
    cmd_bus.row       = '0;
    cmd_bus.col       = '0;
    cmd_bus.half_size = '0;
    cmd_bus.color     = '0;
    cmd_bus.outline   = 1'b0;
    size_reg          = 9'd256;
    bg_reg            = '0;
    send_idle_pct     = 38;
    recv_idle_pct     = 69;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_fill_and_outline();
    test_rejections();
    test_canvas_sizes();
    test_random_traffic(38, 69, $urandom_range(24, 2), 25);
    test_random_traffic(69, 38, 256, 25);
    test_random_traffic(0, 0, $urandom_range(511, 257), 25);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && answers_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sde_pkg.sv
sv/sde_cmd_if.sv
sv/sde_res_if.sv
sv/sde_front.sv
sv/sde_queue.sv
sv/sde_back.sv
sv/square_draw_engine.sv
test/tb.sv
